>>> sv/wl16_pkg.sv
package wl16_pkg;

    // Field and register widths
    localparam int PIX_W  = 16;
    localparam int OUT_W  = 8;
    localparam int WID_W  = 17;
    localparam int IDX_W  = 2;
    localparam int PROD_W = PIX_W + OUT_W;
    localparam int CNT_W  = 3;

    // Mapping constants
    localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;
    localparam logic [OUT_W-1:0] OUT_MAX = 8'd255;
    localparam logic [OUT_W-1:0] OUT_MID = 8'd128;
    localparam logic [OUT_W-1:0] OUT_MIN = 8'd0;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_USE_WINDOW    = 2'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_CENTER = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd2;

    // Register reset values
    localparam logic [PIX_W-1:0] CENTER_RST = 16'd32768;
    localparam logic [WID_W-1:0] WIDTH_RST  = 17'd65535;

    // Request codes
    localparam logic REQ_GATHER = 1'b0;
    localparam logic REQ_MAP    = 1'b1;

    // Last quotient step
    localparam logic [CNT_W-1:0] DIV_LAST = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

>>> sv/window_level_16_to_8.sv
// Channel | Direction | Handshake                  | Payload
// in      | sink      | i_in_valid / o_in_stall    | i_req_type, i_pixel_in, i_frame_start
// out     | source    | o_out_valid / i_out_stall  | o_pixel_out
// cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A gather beat is folded into the frame min/max in the cycle it is taken.
// A map beat goes through bounds, subtract and scale, 8 shared restoring-division
// steps and hand-off; the next beat is taken once the sequencer is back in idle.
// Out-of-range and equal-bound pixels skip the division.
// The output register lets a beat in while a result waits; a second result holds the
// sequencer in its last state. Reset (i_rst_n low, synchronous) clears control and config.
module window_level_16_to_8 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_req_type,
    input  logic [wl16_pkg::PIX_W-1:0] i_pixel_in,
    input  logic                       i_frame_start,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [wl16_pkg::OUT_W-1:0] o_pixel_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [wl16_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [wl16_pkg::WID_W-1:0] i_cfg_data
);
    import wl16_pkg::*;

    t_state             r_state, n_state;
    logic               r_use_window;
    logic [PIX_W-1:0]   r_center;
    logic [WID_W-1:0]   r_width;
    logic [PIX_W-1:0]   r_min, r_max;
    logic [PIX_W-1:0]   r_pix;
    logic [PIX_W-1:0]   r_lo, r_hi;
    logic [PIX_W-1:0]   r_rem;
    logic [PIX_W-1:0]   r_den;
    logic [OUT_W-1:0]   r_num;
    logic [OUT_W-1:0]   r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_pixel_out;

    logic               s_in_acc, s_cfg_acc, s_out_free;
    logic               s_in_stall, s_cfg_ready, s_load_out;
    logic [PIX_W-1:0]   s_half, s_lo, s_hi, s_min_base, s_max_base;
    logic [PIX_W:0]     s_hi_sum;
    logic               s_special;
    logic [OUT_W-1:0]   s_special_val;
    logic [PIX_W-1:0]   s_diff;
    logic [PROD_W-1:0]  s_prod;
    logic [PIX_W:0]     s_trial;
    logic [PIX_W+1:0]   s_sub;
    logic               s_ge;

    assign s_in_acc   = i_in_valid && !s_in_stall;
    assign s_cfg_acc  = i_cfg_valid && s_cfg_ready;
    assign s_out_free = !r_out_valid || !i_out_stall;

    // Window bounds, clamped to the pixel range, or frame min/max when the window is off
    assign s_half   = r_width[WID_W-1:1];
    assign s_hi_sum = {1'b0, r_center} + {1'b0, s_half};
    always_comb begin
        if (r_use_window) begin
            s_lo = (r_center > s_half) ? (r_center - s_half) : '0;
            s_hi = s_hi_sum[PIX_W] ? PIX_MAX : s_hi_sum[PIX_W-1:0];
        end else begin
            s_lo = r_min;
            s_hi = r_max;
        end
    end

    // Special cases, checked in this order
    always_comb begin
        s_special     = 1'b1;
        s_special_val = OUT_MIN;
        priority if (r_pix < r_lo) begin
            s_special_val = OUT_MIN;
        end else if (r_pix > r_hi) begin
            s_special_val = OUT_MAX;
        end else if (r_lo == r_hi) begin
            s_special_val = OUT_MID;
        end else begin
            s_special = 1'b0;
        end
    end

    // 255 * (p - lo) as (x << 8) - x
    assign s_diff = r_pix - r_lo;
    assign s_prod = {s_diff, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, s_diff};

    // Shared restoring-division step
    assign s_trial = {r_rem, r_num[OUT_W-1]};
    assign s_sub   = {1'b0, s_trial} - {2'b00, r_den};
    assign s_ge    = !s_sub[PIX_W+1];

    // Frame statistics base, cleared on frame start
    assign s_min_base = i_frame_start ? PIX_MAX : r_min;
    assign s_max_base = i_frame_start ? '0 : r_max;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_in_acc && i_req_type == REQ_MAP) begin
                    n_state = ST_BOUNDS;
                end
            end
            ST_BOUNDS: n_state = ST_PREP;
            ST_PREP:   n_state = s_special ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_in_stall  = 1'b1;
        s_cfg_ready = 1'b0;
        s_load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_in_stall  = 1'b0;
                s_cfg_ready = 1'b1;
            end
            ST_DONE:   s_load_out = s_out_free;
            default: begin
                s_in_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_use_window <= 1'b0;
            r_center     <= CENTER_RST;
            r_width      <= WIDTH_RST;
            r_min        <= PIX_MAX;
            r_max        <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            if (s_cfg_acc) begin
                unique case (i_cfg_index)
                    REG_USE_WINDOW:    r_use_window <= i_cfg_data[0];
                    REG_WINDOW_CENTER: r_center     <= i_cfg_data[PIX_W-1:0];
                    REG_WINDOW_WIDTH:  r_width      <= i_cfg_data;
                    default:           ;
                endcase
            end
            if (s_in_acc && i_req_type == REQ_GATHER) begin
                r_min <= (i_pixel_in < s_min_base) ? i_pixel_in : s_min_base;
                r_max <= (i_pixel_in > s_max_base) ? i_pixel_in : s_max_base;
            end
            if (s_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_pix <= i_pixel_in;
        end
        if (r_state == ST_BOUNDS) begin
            r_lo <= s_lo;
            r_hi <= s_hi;
        end
        if (r_state == ST_PREP) begin
            r_rem  <= s_prod[PROD_W-1:OUT_W];
            r_num  <= s_prod[OUT_W-1:0];
            r_den  <= r_hi - r_lo;
            r_quot <= s_special_val;
        end
        if (r_state == ST_DIV) begin
            r_rem  <= s_ge ? s_sub[PIX_W-1:0] : s_trial[PIX_W-1:0];
            r_num  <= {r_num[OUT_W-2:0], 1'b0};
            r_quot <= {r_quot[OUT_W-2:0], s_ge};
        end
        if (s_load_out) begin
            r_pixel_out <= r_quot;
        end
    end

    assign o_in_stall  = s_in_stall;
    assign o_cfg_ready = s_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;

    // Partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < r_den)
        else $error("division remainder not below divisor");

    // A map beat starts the sequencer
    a_map_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc && i_req_type == REQ_MAP |=> r_state == ST_BOUNDS)
        else $error("map beat did not start the sequencer");

    // A gathered pixel lies within the statistics
    a_gather_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc && i_req_type == REQ_GATHER
        |=> r_min <= $past(i_pixel_in) && r_max >= $past(i_pixel_in))
        else $error("gathered pixel outside frame min/max");

    // Eight quotient steps, then hand-off
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV && r_cnt == DIV_LAST |=> r_state == ST_DONE)
        else $error("division did not end after eight steps");

endmodule

>>> tb/sv/window_level_16_to_8_test.sv
`timescale 1ns / 1ps

module window_level_16_to_8_test;
    import wl16_pkg::*;

    // Register index past the end of the map: writes to it must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int BEAT_TARGET    = 650;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int HOLD_PHASE     = 3;
    localparam int FRAMES_PER_SET = 6;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // Tracks registers and frame statistics, predicts every mapped pixel
    class mapping_scoreboard;
        logic             use_window;
        logic [PIX_W-1:0] center;
        logic [WID_W-1:0] width;
        logic [PIX_W-1:0] frame_min;
        logic [PIX_W-1:0] frame_max;
        logic [OUT_W-1:0] expected_pixels[$];
        int unsigned      errors;

        function new();
            use_window = 1'b0;
            center     = CENTER_RST;
            width      = WIDTH_RST;
            frame_min  = PIX_MAX;
            frame_max  = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [WID_W-1:0] data);
            case (idx)
                REG_USE_WINDOW:    use_window = data[0];
                REG_WINDOW_CENTER: center     = data[PIX_W-1:0];
                REG_WINDOW_WIDTH:  width      = data;
                default: ;
            endcase
        endfunction

        // Current low/high bounds, window clamped to the pixel range
        function void bounds(output logic [PIX_W-1:0] lo, output logic [PIX_W-1:0] hi);
            logic [PIX_W-1:0] half;
            logic [PIX_W:0]   top;
            half = width[WID_W-1:1];
            top  = {1'b0, center} + {1'b0, half};
            if (use_window) begin
                lo = (center > half) ? center - half : '0;
                hi = top[PIX_W] ? PIX_MAX : top[PIX_W-1:0];
            end else begin
                lo = frame_min;
                hi = frame_max;
            end
        endfunction

        // Exact floor(255 * (p - lo) / (hi - lo)) with the out-of-range cases first
        function logic [OUT_W-1:0] map_value(logic [PIX_W-1:0] p, logic [PIX_W-1:0] lo,
                                             logic [PIX_W-1:0] hi);
            logic [PROD_W-1:0] num;
            if (p < lo)
                return OUT_MIN;
            if (p > hi)
                return OUT_MAX;
            if (lo == hi)
                return OUT_MID;
            num = PROD_W'(p - lo) * PROD_W'(OUT_MAX);
            return OUT_W'(num / PROD_W'(hi - lo));
        endfunction

        function void note_input(logic req, logic [PIX_W-1:0] pix, logic fs);
            logic [PIX_W-1:0] lo, hi;
            if (req == REQ_GATHER) begin
                if (fs) begin
                    frame_min = PIX_MAX;
                    frame_max = '0;
                end
                if (pix < frame_min)
                    frame_min = pix;
                if (pix > frame_max)
                    frame_max = pix;
            end else begin
                bounds(lo, hi);
                expected_pixels.push_back(map_value(pix, lo, hi));
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_pixels.size() == 0) begin
                $error("pixel_out: expected no result, actual %0d", got);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got !== want) begin
                $error("pixel_out: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function void check_drained();
            if (expected_pixels.size() != 0) begin
                $error("pixel_out: expected %0d more results, actual none",
                       expected_pixels.size());
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_req_type;
    logic [PIX_W-1:0]  i_pixel_in;
    logic              i_frame_start;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [OUT_W-1:0]  o_pixel_out;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [WID_W-1:0]  i_cfg_data;

    mapping_scoreboard board = new();
    int unsigned       burst_left = 0;
    int unsigned       beats_sent = 0;
    bit                hold_request = 1'b0;

    window_level_16_to_8 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_out   (o_pixel_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0)
            board.note_input(i_req_type, i_pixel_in, i_frame_start);
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            board.check_result(o_pixel_out);
    end

    // Output stall: changing patterns, plus one long hold-off on request
    initial begin : out_stall_gen
        t_stall_mode mode;
        int unsigned left_in_mode;
        int unsigned period;
        int unsigned tick;
        int unsigned hold_left;
        bit          hold_seen;
        mode         = STALL_NONE;
        left_in_mode = 64;
        period       = 4;
        tick         = 0;
        hold_left    = 0;
        hold_seen    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (left_in_mode == 0) begin
                    mode         = t_stall_mode'($urandom_range(3));
                    left_in_mode = $urandom_range(256, 32);
                    period       = $urandom_range(9, 2);
                end
                left_in_mode--;
                tick++;
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(3) != 0);
                    default:     i_out_stall <= ((tick % period) < (period / 2));
                endcase
            end
        end
    end

    // One input beat; bursts of random length separated by random gaps
    task automatic send_beat(input logic req, input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_pixel_in    <= pix;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // Stop offering beats and wait for every mapped pixel to come back
    task automatic drain();
        int unsigned n;
        n          = 0;
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (board.expected_pixels.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Config beat; valid left high so writes can go back to back
    task automatic cfg_beat(input logic [IDX_W-1:0] idx, input logic [WID_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
        board.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // All three registers, junk in the unused upper bits, sometimes the spare index
    task automatic configure(input logic use_win, input logic [PIX_W-1:0] ctr,
                             input logic [WID_W-1:0] wid);
        cfg_beat(REG_USE_WINDOW, {16'($urandom), use_win});
        cfg_beat(REG_WINDOW_CENTER, {1'($urandom), ctr});
        cfg_beat(REG_WINDOW_WIDTH, wid);
        if ($urandom_range(2) == 0)
            cfg_beat(REG_SPARE, WID_W'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_config();
        logic [PIX_W-1:0] ctr;
        logic [WID_W-1:0] wid;
        case ($urandom_range(3))
            0:       ctr = '0;
            1:       ctr = PIX_MAX;
            default: ctr = PIX_W'($urandom);
        endcase
        case ($urandom_range(4))
            0:       wid = WID_W'($urandom_range(16));
            1:       wid = {WID_W{1'b1}};
            2:       wid = WID_W'($urandom_range(4096));
            default: wid = WID_W'($urandom);
        endcase
        configure($urandom_range(2) != 0, ctr, wid);
    endtask

    // Map pixels lean towards the current bounds and their neighbours
    function automatic logic [PIX_W-1:0] pick_map_pixel();
        logic [PIX_W-1:0] lo, hi;
        board.bounds(lo, hi);
        case ($urandom_range(9))
            0:       return '0;
            1:       return PIX_MAX;
            2:       return lo;
            3:       return hi;
            4:       return lo - 1'b1;
            5:       return hi + 1'b1;
            6, 7:    return (hi >= lo) ? lo + PIX_W'($urandom_range(hi - lo)) : PIX_W'($urandom);
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // A gather pass, mostly opened by frame start, then a run of map requests
    task automatic send_frame();
        int unsigned      n_gather;
        int unsigned      n_map;
        logic [PIX_W-1:0] base;
        logic             narrow;
        logic             fs;
        n_gather = $urandom_range(8, 1);
        n_map    = $urandom_range(10, 1);
        base     = PIX_W'($urandom);
        narrow   = ($urandom_range(3) == 0);
        for (int i = 0; i < n_gather; i++) begin
            fs = (i == 0) ? ($urandom_range(7) != 0) : ($urandom_range(15) == 0);
            send_beat(REQ_GATHER, narrow ? base + PIX_W'($urandom_range(2)) : PIX_W'($urandom),
                      fs);
        end
        for (int i = 0; i < n_map; i++)
            send_beat(REQ_MAP, pick_map_pixel(), 1'($urandom));
    endtask

    initial begin : stimulus
        int unsigned phase;
        phase         = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_GATHER;
        i_pixel_in    = '0;
        i_frame_start = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_USE_WINDOW;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Nothing gathered yet: min above max, so every pixel is out of range
        send_beat(REQ_MAP, '0, 1'b0);
        send_beat(REQ_MAP, PIX_MAX, 1'b1);
        send_beat(REQ_MAP, 16'd1234, 1'b0);
        // Frame of 1000..3000, pixels either side of and inside it
        send_beat(REQ_GATHER, 16'd3000, 1'b1);
        send_beat(REQ_GATHER, 16'd1000, 1'b0);
        send_beat(REQ_MAP, 16'd999, 1'b0);
        send_beat(REQ_MAP, 16'd1001, 1'b0);
        send_beat(REQ_MAP, 16'd2999, 1'b0);
        send_beat(REQ_MAP, 16'd3001, 1'b0);
        // Single-pixel frame: equal bounds
        send_beat(REQ_GATHER, 16'd5000, 1'b1);
        send_beat(REQ_MAP, 16'd5000, 1'b0);
        send_beat(REQ_MAP, 16'd4999, 1'b0);
        send_beat(REQ_MAP, 16'd5001, 1'b0);
        // Full-range frame
        send_beat(REQ_GATHER, '0, 1'b1);
        send_beat(REQ_GATHER, PIX_MAX, 1'b0);
        send_beat(REQ_MAP, 16'd32768, 1'b0);
        send_beat(REQ_MAP, PIX_MAX, 1'b0);
        drain();

        // Window spanning the whole range
        configure(1'b1, '0, {WID_W{1'b1}});
        send_beat(REQ_MAP, 16'd1, 1'b0);
        send_beat(REQ_MAP, 16'd65534, 1'b0);
        drain();
        // Zero width at the top: equal bounds at full scale
        configure(1'b1, PIX_MAX, '0);
        send_beat(REQ_MAP, PIX_MAX, 1'b0);
        send_beat(REQ_MAP, 16'd65534, 1'b0);
        drain();
        // Low bound clamped at zero
        configure(1'b1, 16'd100, 17'd1000);
        send_beat(REQ_MAP, 16'd600, 1'b0);
        send_beat(REQ_MAP, 16'd601, 1'b0);
        drain();
        // High bound clamped at full scale
        configure(1'b1, 16'd65500, 17'd201);
        send_beat(REQ_MAP, 16'd65400, 1'b0);

        // Random frames under a fresh setting each phase
        while (beats_sent < BEAT_TARGET) begin
            drain();
            random_config();
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;
            repeat (FRAMES_PER_SET) begin
                if ($urandom_range(9) == 0)
                    send_beat(1'($urandom), PIX_W'($urandom), 1'($urandom));
                else
                    send_frame();
            end
            phase++;
        end

        drain();
        board.check_drained();
        if (board.errors == 0)
            $display("** window_level_16_to_8: PASSED **");
        else
            $display("** window_level_16_to_8: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("** window_level_16_to_8: FAILED **");
        $finish;
    end

endmodule
